### hw/rtl/ucdw_pkg.sv
// ----------------------------------------------------------------------------
// ucdw_pkg
// Shared types and constants of the configuration descriptor walker: record
// layout, queue item layout, descriptor type codes and register indexes.
// ----------------------------------------------------------------------------
package ucdw_pkg;

  // default table sizes
  localparam int DEFAULT_MAX_INTERFACES = 8;
  localparam int DEFAULT_MAX_ENDPOINTS  = 8;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_WANT_CLASS    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WANT_SUBCLASS = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WANT_PROTOCOL = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_PACKET    = 4'd3;

  // descriptor type codes
  localparam logic [7:0] TYPE_CONFIG = 8'h02;
  localparam logic [7:0] TYPE_IFACE  = 8'h04;
  localparam logic [7:0] TYPE_EP     = 8'h05;
  localparam logic [7:0] TYPE_HID    = 8'h21;

  // length limits
  localparam logic [7:0] HDR_MIN_LEN  = 8'd4;
  localparam logic [7:0] DESC_MIN_LEN = 8'd2;
  localparam logic [2:0] HDR_MIN_BYTES = 3'd4;

  // captured bytes of a descriptor (bytes 2..7)
  localparam int CAPTURE_DEPTH = 6;

  // endpoint attribute codes
  localparam logic [1:0] XFER_INTERRUPT = 2'd3;

  // record kinds
  localparam logic [2:0] KIND_IFACE     = 3'd0;
  localparam logic [2:0] KIND_EP        = 3'd1;
  localparam logic [2:0] KIND_HID       = 3'd2;
  localparam logic [2:0] KIND_DONE_OK   = 3'd3;
  localparam logic [2:0] KIND_DONE_ERR  = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  iface_slot;
    logic [3:0]  ep_slot;
    logic [7:0]  iface_class;
    logic [7:0]  iface_subclass;
    logic [7:0]  iface_protocol;
    logic [7:0]  ep_addr;
    logic [1:0]  xfer_type;
    logic [15:0] pkt_size;
    logic        match;
    logic [4:0]  total;
  } record_t;

  // what one input byte leaves for the back: a descriptor record, a done
  // record, or both
  typedef struct packed {
    logic    has_desc;
    record_t desc;
    logic    has_done;
    record_t done;
  } entry_t;

endpackage

### hw/rtl/ucdw_queue.sv
// ----------------------------------------------------------------------------
// ucdw_queue
// Short register queue that carries per-byte result items from the front
// to the back.
// ----------------------------------------------------------------------------
module ucdw_queue #(
  parameter int DEPTH = ucdw_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ucdw_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output ucdw_pkg::entry_t head
);
  import ucdw_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t         slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

### hw/rtl/ucdw_front.sv
// ----------------------------------------------------------------------------
// ucdw_front
// Byte walker: holds configuration registers and walk state, takes one blob
// byte per cycle while q_full is low, classifies it, queues its records.
// ----------------------------------------------------------------------------
module ucdw_front #(
  parameter int MAX_INTERFACES = ucdw_pkg::DEFAULT_MAX_INTERFACES,
  parameter int MAX_ENDPOINTS  = ucdw_pkg::DEFAULT_MAX_ENDPOINTS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ucdw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ucdw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       data_byte,
  input  logic                             last_byte,
  input  logic                             q_full,
  output logic                             push,
  output ucdw_pkg::entry_t                 push_entry
);
  import ucdw_pkg::*;

  // configuration registers
  logic [7:0]  want_class;
  logic [7:0]  want_subclass;
  logic [7:0]  want_protocol;
  logic [15:0] min_packet;

  // walk state
  logic [2:0]  bytes_seen;
  logic        in_header;
  logic [7:0]  desc_length;
  logic [7:0]  desc_type;
  logic [7:0]  desc_position;
  logic        error_seen;
  logic [7:0]  capture [CAPTURE_DEPTH];
  logic [4:0]  iface_count;
  logic        cur_iface_valid;
  logic [4:0]  cur_ep_count;
  logic        match_iface_valid;
  logic [3:0]  match_iface_slot;
  logic        match_ep_valid;
  logic [15:0] match_mp;
  logic [7:0]  match_addr;
  logic [3:0]  match_ep_slot;

  // next values
  logic [2:0]  bytes_seen_next;
  logic        in_header_next;
  logic [7:0]  desc_length_next;
  logic [7:0]  desc_type_next;
  logic [7:0]  desc_position_next;
  logic        error_seen_next;
  logic [7:0]  capture_next [CAPTURE_DEPTH];
  logic [4:0]  iface_count_next;
  logic        cur_iface_valid_next;
  logic [4:0]  cur_ep_count_next;
  logic        match_iface_valid_next;
  logic [3:0]  match_iface_slot_next;
  logic        match_ep_valid_next;
  logic [15:0] match_mp_next;
  logic [7:0]  match_addr_next;
  logic [3:0]  match_ep_slot_next;

  logic        accept;
  logic        complete;
  logic        error_final;
  logic [7:0]  ep_addr;
  logic [1:0]  ep_xfer;
  logic [15:0] ep_mp;
  logic [3:0]  cur_islot;
  record_t     desc_rec;
  logic        has_desc;
  record_t     done_rec;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~q_full;
  assign accept    = in_valid & in_ready;
  assign push      = accept & (has_desc | last_byte);

  always_comb begin
    push_entry          = '0;
    push_entry.has_desc = has_desc;
    push_entry.desc     = desc_rec;
    push_entry.has_done = last_byte;
    push_entry.done     = done_rec;
  end

  // byte walk, descriptor completion and done status
  always_comb begin
    bytes_seen_next        = bytes_seen;
    in_header_next         = in_header;
    desc_length_next       = desc_length;
    desc_type_next         = desc_type;
    desc_position_next     = desc_position;
    error_seen_next        = error_seen;
    capture_next           = capture;
    iface_count_next       = iface_count;
    cur_iface_valid_next   = cur_iface_valid;
    cur_ep_count_next      = cur_ep_count;
    match_iface_valid_next = match_iface_valid;
    match_iface_slot_next  = match_iface_slot;
    match_ep_valid_next    = match_ep_valid;
    match_mp_next          = match_mp;
    match_addr_next        = match_addr;
    match_ep_slot_next     = match_ep_slot;
    complete               = 1'b0;
    has_desc               = 1'b0;
    desc_rec               = '0;
    done_rec               = '0;
    error_final            = 1'b0;

    if (!error_seen) begin
      if (in_header) begin
        // configuration header: check length and type, then skip it
        if (desc_position == 8'd0) begin
          desc_length_next = data_byte;
        end else if (desc_position == 8'd1) begin
          desc_type_next = data_byte;
          if (desc_length < HDR_MIN_LEN || data_byte != TYPE_CONFIG) begin
            error_seen_next = 1'b1;
          end
        end
        if (bytes_seen < HDR_MIN_BYTES) begin
          bytes_seen_next = bytes_seen + 3'd1;
        end
        desc_position_next = desc_position + 8'd1;
        if (!error_seen_next && desc_position_next >= 8'd2 &&
            desc_position_next == desc_length_next) begin
          in_header_next     = 1'b0;
          desc_position_next = '0;
        end
      end else begin
        // descriptor body: length, type, then captured bytes
        if (desc_position == 8'd0) begin
          desc_length_next = data_byte;
          desc_type_next   = '0;
          for (int i = 0; i < CAPTURE_DEPTH; i++) begin
            capture_next[i] = '0;
          end
          if (data_byte < DESC_MIN_LEN) begin
            error_seen_next = 1'b1;
          end
        end else if (desc_position == 8'd1) begin
          desc_type_next = data_byte;
        end else begin
          for (int i = 0; i < CAPTURE_DEPTH; i++) begin
            if (desc_position == 8'(i + 2)) begin
              capture_next[i] = data_byte;
            end
          end
        end
        if (!error_seen_next) begin
          desc_position_next = desc_position + 8'd1;
          if (desc_position_next >= 8'd2 && desc_position_next == desc_length_next) begin
            complete           = 1'b1;
            desc_position_next = '0;
          end
        end
      end
    end

    ep_addr   = capture_next[0];
    ep_xfer   = capture_next[1][1:0];
    ep_mp     = {capture_next[3], capture_next[2]};
    cur_islot = 4'(iface_count - 5'd1);

    // finished descriptor
    if (complete) begin
      if (desc_type_next == TYPE_IFACE) begin
        if (iface_count < 5'(MAX_INTERFACES)) begin
          iface_count_next     = iface_count + 5'd1;
          cur_iface_valid_next = 1'b1;
          cur_ep_count_next    = '0;
          if (!match_iface_valid && capture_next[3] == want_class &&
              capture_next[4] == want_subclass && capture_next[5] == want_protocol) begin
            match_iface_valid_next = 1'b1;
            match_iface_slot_next  = iface_count[3:0];
          end
          has_desc                = 1'b1;
          desc_rec.kind           = KIND_IFACE;
          desc_rec.iface_slot     = iface_count[3:0];
          desc_rec.iface_class    = capture_next[3];
          desc_rec.iface_subclass = capture_next[4];
          desc_rec.iface_protocol = capture_next[5];
        end else begin
          cur_iface_valid_next = 1'b0;
        end
      end else if (desc_type_next == TYPE_EP) begin
        if (cur_iface_valid && cur_ep_count < 5'(MAX_ENDPOINTS)) begin
          cur_ep_count_next = cur_ep_count + 5'd1;
          if (match_iface_valid && !match_ep_valid && match_iface_slot == cur_islot &&
              ep_addr[7] && ep_xfer == XFER_INTERRUPT && ep_mp >= min_packet) begin
            match_ep_valid_next = 1'b1;
            match_mp_next       = ep_mp;
            match_addr_next     = ep_addr;
            match_ep_slot_next  = cur_ep_count[3:0];
          end
          has_desc            = 1'b1;
          desc_rec.kind       = KIND_EP;
          desc_rec.iface_slot = cur_islot;
          desc_rec.ep_slot    = cur_ep_count[3:0];
          desc_rec.ep_addr    = ep_addr;
          desc_rec.xfer_type  = ep_xfer;
          desc_rec.pkt_size   = ep_mp;
        end
      end else if (desc_type_next == TYPE_HID) begin
        if (cur_iface_valid) begin
          has_desc            = 1'b1;
          desc_rec.kind       = KIND_HID;
          desc_rec.iface_slot = cur_islot;
        end
      end
    end
    desc_rec.total = iface_count_next;

    // end of blob: status and matched endpoint
    error_final = error_seen_next;
    if (!error_seen_next) begin
      if (in_header_next && bytes_seen_next < HDR_MIN_BYTES) begin
        error_final = 1'b1;
      end
      if (!in_header_next && desc_position_next != 8'd0) begin
        error_final = 1'b1;
      end
    end
    done_rec.kind  = error_final ? KIND_DONE_ERR : KIND_DONE_OK;
    done_rec.total = iface_count_next;
    if (!error_final && match_ep_valid_next) begin
      done_rec.iface_slot = match_iface_slot_next;
      done_rec.ep_slot    = match_ep_slot_next;
      done_rec.ep_addr    = match_addr_next;
      done_rec.xfer_type  = XFER_INTERRUPT;
      done_rec.pkt_size   = match_mp_next;
      done_rec.match      = 1'b1;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      want_class    <= '0;
      want_subclass <= '0;
      want_protocol <= '0;
      min_packet    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WANT_CLASS:    want_class    <= cfg_data[7:0];
        REG_WANT_SUBCLASS: want_subclass <= cfg_data[7:0];
        REG_WANT_PROTOCOL: want_protocol <= cfg_data[7:0];
        REG_MIN_PACKET:    min_packet    <= cfg_data;
        default: ;
      endcase
    end
  end

  // walk state, back to reset after each last byte
  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      bytes_seen        <= '0;
      in_header         <= 1'b1;
      desc_length       <= '0;
      desc_type         <= '0;
      desc_position     <= '0;
      error_seen        <= 1'b0;
      for (int i = 0; i < CAPTURE_DEPTH; i++) begin
        capture[i] <= '0;
      end
      iface_count       <= '0;
      cur_iface_valid   <= 1'b0;
      cur_ep_count      <= '0;
      match_iface_valid <= 1'b0;
      match_iface_slot  <= '0;
      match_ep_valid    <= 1'b0;
      match_mp          <= '0;
      match_addr        <= '0;
      match_ep_slot     <= '0;
    end else if (accept) begin
      bytes_seen        <= bytes_seen_next;
      in_header         <= in_header_next;
      desc_length       <= desc_length_next;
      desc_type         <= desc_type_next;
      desc_position     <= desc_position_next;
      error_seen        <= error_seen_next;
      capture           <= capture_next;
      iface_count       <= iface_count_next;
      cur_iface_valid   <= cur_iface_valid_next;
      cur_ep_count      <= cur_ep_count_next;
      match_iface_valid <= match_iface_valid_next;
      match_iface_slot  <= match_iface_slot_next;
      match_ep_valid    <= match_ep_valid_next;
      match_mp          <= match_mp_next;
      match_addr        <= match_addr_next;
      match_ep_slot     <= match_ep_slot_next;
    end
  end

endmodule

### hw/rtl/ucdw_back.sv
// ----------------------------------------------------------------------------
// ucdw_back
// Result issue: sends the records of queued items through an output register,
// one per cycle while out_ready is high, marking each byte's last record.
// ----------------------------------------------------------------------------
module ucdw_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  ucdw_pkg::entry_t  q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output ucdw_pkg::record_t out_rec,
  output logic              out_final
);
  import ucdw_pkg::*;

  logic    phase;
  logic    load;
  logic    two;
  logic    finish;
  record_t sel;

  // pick the record of the head item that goes out next
  assign load   = ~out_valid | out_ready;
  assign two    = q_head.has_desc & q_head.has_done;
  assign finish = ~(two & ~phase);
  assign sel    = (q_head.has_desc && !phase) ? q_head.desc : q_head.done;
  assign q_pop  = load & ~q_empty & finish;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= ~q_empty;
      if (!q_empty) begin
        phase <= ~finish;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_rec   <= sel;
      out_final <= finish;
    end
  end

endmodule

### hw/rtl/usb_config_descriptor_walker.sv
// ----------------------------------------------------------------------------
// usb_config_descriptor_walker
// Walks a configuration descriptor blob byte by byte and reports interface,
// endpoint and HID records plus a final status with the matched endpoint.
// ----------------------------------------------------------------------------
// The block takes one blob byte per clock cycle while the queue has room;
// the byte walker checks and classifies each byte combinationally. Records
// go through a two-item queue and an output register, one record per cycle
// while out_ready is high, so a byte that completes a descriptor and also
// ends the blob gives two records, descriptor first. Configuration writes
// are taken at any time with cfg_ready held high; write them only while no
// blob is being walked.
module usb_config_descriptor_walker #(
  parameter int MAX_INTERFACES = ucdw_pkg::DEFAULT_MAX_INTERFACES,
  parameter int MAX_ENDPOINTS  = ucdw_pkg::DEFAULT_MAX_ENDPOINTS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ucdw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ucdw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       data_byte,
  input  logic                             last_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       record_kind,
  output logic [3:0]                       interface_slot,
  output logic [3:0]                       endpoint_slot,
  output logic [7:0]                       interface_class,
  output logic [7:0]                       interface_subclass,
  output logic [7:0]                       interface_protocol,
  output logic [7:0]                       endpoint_address,
  output logic [1:0]                       xfer_kind,
  output logic [15:0]                      packet_size,
  output logic                             match_found,
  output logic [4:0]                       interfaces_total,
  output logic                             final_record
);
  import ucdw_pkg::*;

  logic    q_full;
  logic    q_empty;
  logic    push;
  logic    pop;
  entry_t  push_entry;
  entry_t  head;
  record_t rec;

  ucdw_front #(
    .MAX_INTERFACES(MAX_INTERFACES),
    .MAX_ENDPOINTS (MAX_ENDPOINTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .push      (push),
    .push_entry(push_entry)
  );

  ucdw_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  ucdw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (head),
    .q_pop    (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rec  (rec),
    .out_final(final_record)
  );

  // record fields to ports
  assign record_kind        = rec.kind;
  assign interface_slot     = rec.iface_slot;
  assign endpoint_slot      = rec.ep_slot;
  assign interface_class    = rec.iface_class;
  assign interface_subclass = rec.iface_subclass;
  assign interface_protocol = rec.iface_protocol;
  assign endpoint_address   = rec.ep_addr;
  assign xfer_kind          = rec.xfer_type;
  assign packet_size        = rec.pkt_size;
  assign match_found        = rec.match;
  assign interfaces_total   = rec.total;

endmodule
